// ----- rtl/fbsik_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the
// five-bar SCARA step-limit IK unit. No dependencies.
package fbsik_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER_LINK = 4'd0,
    CFG_OUTER_LINK = 4'd1,
    CFG_BASE_HALF  = 4'd2,
    CFG_MAX_STEP   = 4'd3
  } cfg_index_e;

  // reset values
  localparam logic [13:0] INNER_LINK_RST = 14'd1600;
  localparam logic [13:0] OUTER_LINK_RST = 14'd3200;
  localparam logic [13:0] BASE_HALF_RST  = 14'd800;
  localparam logic [13:0] MAX_STEP_RST   = 14'd32;
  localparam logic signed [15:0] TARGET_X_RST = 16'sd0;
  localparam logic signed [15:0] TARGET_Y_RST = 16'sd5173;

  // angles in radians * 2^24; output limits in radians * 2^12
  localparam logic signed [29:0] Q24_HALF_PI = 30'sd26353589;
  localparam logic signed [29:0] Q24_TWO_PI  = 30'sd105414357;
  localparam logic signed [19:0] OUT_MIN     = -20'sd19302;
  localparam logic signed [19:0] OUT_MAX     = 20'sd6434;

  // target queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } target_t;

  typedef struct packed {
    logic signed [15:0] left_angle;
    logic signed [15:0] right_angle;
    logic               reachable;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } result_t;

  // atan(2^-i) in radians * 2^24
  function automatic logic [23:0] atan_q24(input logic [4:0] idx);
    logic [23:0] v;
    unique case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/fbsik_isqrt.sv -----
// Digit-by-digit floor integer square root, two input bits per cycle.
// Depends on nothing.
module fbsik_isqrt #(
  parameter int W = 50
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   val_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);
  localparam int RW = W / 2;
  localparam int CW = $clog2(RW + 1);

  logic [W-1:0]  val_q;
  logic [RW+2:0] rem_q;
  logic [RW-1:0] root_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;

  logic [RW+2:0] rem_sh, trial;

  // bring down two bits and try the next root bit
  always_comb begin
    rem_sh = {rem_q[RW:0], val_q[W-1:W-2]};
    trial  = {1'b0, root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(RW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      val_q <= {val_q[W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ----- rtl/fbsik_cordic.sv -----
// CORDIC vectoring atan2 with operand normalization and quadrant pre-rotation.
// Depends on fbsik_pkg (arctangent table, half pi).
module fbsik_cordic
  import fbsik_pkg::*;
#(
  parameter int ITERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] y_i,
  input  logic signed [47:0] x_i,
  output logic               done_o,
  output logic signed [27:0] z_o
);
  localparam int IW = $clog2(ITERS);
  localparam logic [47:0] P41 = 48'h0200_0000_0000;
  localparam logic [47:0] P40 = 48'h0100_0000_0000;
  localparam logic [47:0] P33 = 48'h0002_0000_0000;

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_DONE} cstate_e;

  cstate_e            state_q;
  logic signed [47:0] x_q, y_q;
  logic signed [27:0] z_q;
  logic [IW-1:0]      i_q;

  logic [47:0]        ax, ay, m;
  logic signed [47:0] xs, ys;
  logic signed [27:0] ang;

  always_comb begin
    ax  = x_q[47] ? 48'(-x_q) : 48'(x_q);
    ay  = y_q[47] ? 48'(-y_q) : 48'(y_q);
    m   = (ax > ay) ? ax : ay;
    xs  = x_q >>> i_q;
    ys  = y_q >>> i_q;
    ang = $signed({4'b0000, atan_q24(5'(i_q))});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      i_q     <= '0;
    end else begin
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            i_q     <= '0;
            state_q <= (x_i == '0 && y_i == '0) ? C_DONE : C_NORM;
          end
        end
        C_NORM: begin
          if (m < P41 && m >= P40) state_q <= C_ITER;
        end
        C_ITER: begin
          if (i_q == IW'(ITERS - 1)) state_q <= C_DONE;
          i_q <= i_q + 1'b1;
        end
        C_DONE: state_q <= C_IDLE;
        default: state_q <= C_IDLE;
      endcase
    end
  end

  // datapath: normalize, pre-rotate, rotate
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_IDLE: begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
      C_NORM: begin
        if (m >= P41) begin
          x_q <= x_q >>> 1;
          y_q <= y_q >>> 1;
        end else if (m < P33) begin
          x_q <= x_q <<< 8;
          y_q <= y_q <<< 8;
        end else if (m < P40) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end else if (x_q < 0) begin
          if (y_q >= 0) begin
            x_q <= y_q;
            y_q <= -x_q;
            z_q <= 28'(Q24_HALF_PI);
          end else begin
            x_q <= -y_q;
            y_q <= x_q;
            z_q <= -28'(Q24_HALF_PI);
          end
        end
      end
      C_ITER: begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + ang;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - ang;
        end
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == C_DONE);
  assign z_o    = z_q;
endmodule

// ----- rtl/fbsik_front.sv -----
// Front end: accepts requests, runs the step limiter, keeps the target state.
// Depends on fbsik_pkg and fbsik_isqrt.
module fbsik_front
  import fbsik_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic signed [15:0] request_x_i,
  input  logic signed [15:0] request_y_i,
  input  logic [13:0]        max_step_i,
  output logic               q_push_o,
  input  logic               q_full_i,
  output target_t            q_data_o
);
  localparam int QB = 15;

  typedef enum logic [3:0] {
    F_IDLE, F_SQ_X, F_SQ_Y, F_MS2, F_CMP, F_SQRT_GO, F_SQRT_WAIT,
    F_NUM, F_DIV_INIT, F_DIV, F_APPLY, F_PUSH
  } fstate_e;

  fstate_e            state_q;
  logic signed [15:0] tx_q, ty_q, rx_q, ry_q, nx_q, ny_q;
  logic signed [16:0] dx_q, dy_q;
  logic signed [35:0] p_q;
  logic [33:0]        d2_q;
  logic [24:0]        dist_q;
  logic [42:0]        rem_q;
  logic [QB-1:0]      quo_q;
  logic [3:0]         k_q;
  logic               neg_q, axis_q;

  logic signed [17:0] mul_a, mul_b;
  logic               sq_start, sq_done;
  logic [24:0]        sq_root;
  logic signed [43:0] nw;
  logic [42:0]        na, dsh;
  logic signed [17:0] base, moved;
  logic signed [15:0] sat;

  fbsik_isqrt #(.W(50)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   ({d2_q[32:0], 16'h0000, 1'b0} >> 1),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      F_SQ_X: begin mul_a = 18'(dx_q); mul_b = 18'(dx_q); end
      F_SQ_Y: begin mul_a = 18'(dy_q); mul_b = 18'(dy_q); end
      F_MS2:  begin mul_a = $signed({4'b0, max_step_i}); mul_b = $signed({4'b0, max_step_i}); end
      F_NUM:  begin
        mul_a = axis_q ? 18'(dy_q) : 18'(dx_q);
        mul_b = $signed({4'b0, max_step_i});
      end
      default: ;
    endcase
  end

  // divider operands and axis update
  always_comb begin
    nw    = {p_q[35:0], 8'h00};
    na    = nw[43] ? 43'(-nw) : 43'(nw);
    dsh   = 43'({dist_q, 1'b0}) << k_q;
    base  = axis_q ? 18'(ty_q) : 18'(tx_q);
    moved = neg_q ? base - $signed({3'b0, quo_q}) : base + $signed({3'b0, quo_q});
    if (moved > 18'sd32767)       sat = 16'sh7fff;
    else if (moved < -18'sd32768) sat = 16'sh8000;
    else                          sat = moved[15:0];
  end

  assign sq_start = (state_q == F_SQRT_GO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      tx_q    <= TARGET_X_RST;
      ty_q    <= TARGET_Y_RST;
      axis_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        F_IDLE:      if (push_i) state_q <= F_SQ_X;
        F_SQ_X:      state_q <= F_SQ_Y;
        F_SQ_Y:      state_q <= F_MS2;
        F_MS2:       state_q <= F_CMP;
        F_CMP: begin
          axis_q  <= 1'b0;
          state_q <= (d2_q > 34'(p_q[27:0])) ? F_SQRT_GO : F_PUSH;
        end
        F_SQRT_GO:   state_q <= F_SQRT_WAIT;
        F_SQRT_WAIT: if (sq_done) state_q <= F_NUM;
        F_NUM:       state_q <= F_DIV_INIT;
        F_DIV_INIT: begin
          k_q     <= 4'(QB - 1);
          state_q <= F_DIV;
        end
        F_DIV: begin
          if (k_q == '0) state_q <= F_APPLY;
          else           k_q <= k_q - 1'b1;
        end
        F_APPLY: begin
          axis_q  <= 1'b1;
          state_q <= axis_q ? F_PUSH : F_NUM;
        end
        F_PUSH: begin
          if (!q_full_i) begin
            tx_q    <= nx_q;
            ty_q    <= ny_q;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    unique case (state_q)
      F_IDLE: begin
        rx_q <= request_x_i;
        ry_q <= request_y_i;
        dx_q <= $signed({request_x_i[15], request_x_i}) - $signed({tx_q[15], tx_q});
        dy_q <= $signed({request_y_i[15], request_y_i}) - $signed({ty_q[15], ty_q});
      end
      F_SQ_Y: d2_q <= 34'(p_q[32:0]);
      F_MS2:  d2_q <= d2_q + 34'(p_q[32:0]);
      F_CMP: begin
        nx_q <= rx_q;
        ny_q <= ry_q;
      end
      F_SQRT_WAIT: if (sq_done) dist_q <= sq_root;
      F_DIV_INIT: begin
        neg_q <= nw[43];
        rem_q <= {na[41:0], 1'b0} + 43'(dist_q);
        quo_q <= '0;
      end
      F_DIV: begin
        if (rem_q >= dsh) begin
          rem_q      <= rem_q - dsh;
          quo_q[k_q] <= 1'b1;
        end
      end
      F_APPLY: begin
        if (axis_q) ny_q <= sat;
        else        nx_q <= sat;
      end
      default: ;
    endcase
  end

  assign full_o   = (state_q != F_IDLE);
  assign q_push_o = (state_q == F_PUSH) && !q_full_i;
  assign q_data_o = '{x: nx_q, y: ny_q};
endmodule

// ----- rtl/fbsik_queue.sv -----
// Short target queue that decouples the step limiter from the IK solver.
// Depends on fbsik_pkg (target_t, QUEUE_DEPTH).
module fbsik_queue
  import fbsik_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  target_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output target_t data_o
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  target_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
endmodule

// ----- rtl/fbsik_back.sv -----
// Back end: two-arm five-bar inverse kinematics with a shared multiplier,
// square root and CORDIC unit, plus the result register.
// Depends on fbsik_pkg, fbsik_isqrt and fbsik_cordic.
module fbsik_back
  import fbsik_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [13:0] inner_link_i,
  input  logic [13:0] outer_link_i,
  input  logic [13:0] base_half_i,
  input  logic        q_valid_i,
  input  target_t     q_data_i,
  output logic        q_pop_o,
  output logic        res_valid_o,
  input  logic        res_pop_i,
  output result_t     res_o
);
  typedef enum logic [4:0] {
    B_IDLE, B_DX2, B_DY2, B_SUM2, B_DIFF2, B_L1SQ, B_L2SQ, B_L1L2, B_CHECK,
    B_PROD, B_SQRT_GO, B_SQRT_WAIT, B_CY, B_T, B_CX, B_BETA_GO, B_BETA_WAIT,
    B_ALPHA_GO, B_ALPHA_WAIT, B_NEXT, B_OUT
  } bstate_e;

  bstate_e            state_q;
  target_t            tgt_q;
  logic               arm_q, ok_q, res_valid_q;
  result_t            res_q;
  logic signed [63:0] p_q;
  logic [35:0]        d2_q;
  logic [29:0]        sumsq_q, den_q, dma_q, dpa_q, s_q;
  logic [27:0]        diffsq_q, l1sq_q, l2sq_q;
  logic signed [31:0] num_q;
  logic signed [47:0] cy_q, t_q;
  logic signed [27:0] la_q, lb_q, ra_q, rb_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [17:0] dx;
  logic [14:0]        sum;
  logic [13:0]        diff;
  logic [29:0]        den_c;
  logic signed [37:0] num_w;
  logic [31:0]        an_w;
  logic [29:0]        an;
  logic               sq_start, sq_done, co_start, co_done;
  logic [29:0]        sq_root;
  logic signed [47:0] co_y, co_x;
  logic signed [27:0] co_z;
  logic signed [28:0] th_l, th_r;

  // arm geometry
  always_comb begin
    dx   = arm_q ? $signed({{2{tgt_q.x[15]}}, tgt_q.x}) - $signed({4'b0, base_half_i})
                 : $signed({{2{tgt_q.x[15]}}, tgt_q.x}) + $signed({4'b0, base_half_i});
    sum  = 15'(inner_link_i) + 15'(outer_link_i);
    diff = (outer_link_i >= inner_link_i) ? outer_link_i - inner_link_i
                                          : inner_link_i - outer_link_i;
    den_c = {p_q[28:0], 1'b0};
    num_w = $signed({2'b0, d2_q}) - $signed({10'b0, l1sq_q}) - $signed({10'b0, l2sq_q});
    an_w  = num_w[37] ? 32'(-num_w) : 32'(num_w);
    an    = (an_w > 32'(den_c)) ? den_c : an_w[29:0];
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      B_DX2:   begin mul_a = 32'(dx); mul_b = 32'(dx); end
      B_DY2:   begin mul_a = 32'(tgt_q.y); mul_b = 32'(tgt_q.y); end
      B_SUM2:  begin mul_a = $signed({17'b0, sum}); mul_b = $signed({17'b0, sum}); end
      B_DIFF2: begin mul_a = $signed({18'b0, diff}); mul_b = $signed({18'b0, diff}); end
      B_L1SQ:  begin
        mul_a = $signed({18'b0, inner_link_i}); mul_b = $signed({18'b0, inner_link_i});
      end
      B_L2SQ:  begin
        mul_a = $signed({18'b0, outer_link_i}); mul_b = $signed({18'b0, outer_link_i});
      end
      B_L1L2:  begin
        mul_a = $signed({18'b0, inner_link_i}); mul_b = $signed({18'b0, outer_link_i});
      end
      B_PROD:  begin mul_a = $signed({2'b0, dma_q}); mul_b = $signed({2'b0, dpa_q}); end
      B_CY:    begin mul_a = $signed({18'b0, outer_link_i}); mul_b = $signed({2'b0, s_q}); end
      B_T:     begin mul_a = $signed({18'b0, inner_link_i}); mul_b = $signed({2'b0, den_q}); end
      B_CX:    begin mul_a = $signed({18'b0, outer_link_i}); mul_b = num_q; end
      default: ;
    endcase
  end

  assign sq_start = (state_q == B_SQRT_GO);
  assign co_start = (state_q == B_BETA_GO) || (state_q == B_ALPHA_GO);
  always_comb begin
    if (state_q == B_BETA_GO) begin
      co_y = cy_q;
      co_x = t_q;
    end else begin
      co_y = 48'(tgt_q.y);
      co_x = 48'(dx);
    end
  end

  fbsik_isqrt #(.W(60)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (p_q[59:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // beta's x operand is l1*den + l2*num; the second term lands in p_q
  // the cycle the unit starts, so it is added at the port
  fbsik_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (co_start),
    .y_i     (co_y),
    .x_i     ((state_q == B_BETA_GO) ? co_x + $signed(p_q[47:0]) : co_x),
    .done_o  (co_done),
    .z_o     (co_z)
  );

  // map a joint angle to a clamped motor command; the block below combines shoulder angles for the elbow mode
  function automatic logic signed [15:0] motor_out(input logic signed [28:0] th);
    logic signed [29:0] t;
    logic signed [30:0] v;
    logic signed [18:0] sh;
    logic signed [15:0] r;
    t  = th[28] ? 30'(th) + Q24_TWO_PI : 30'(th);
    v  = 31'(Q24_HALF_PI) - 31'(t) + 31'sd2048;
    sh = 19'(v >>> 12);
    if (20'(sh) < OUT_MIN)      r = 16'(OUT_MIN);
    else if (20'(sh) > OUT_MAX) r = 16'(OUT_MAX);
    else                        r = sh[15:0];
    return r;
  endfunction

  always_comb begin
    if (!tgt_q.y[15]) begin
      th_l = 29'(la_q) + 29'(lb_q);
      th_r = 29'(ra_q) - 29'(rb_q);
    end else begin
      th_l = 29'(la_q) - 29'(lb_q);
      th_r = 29'(ra_q) + 29'(rb_q);
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      arm_q       <= 1'b0;
      ok_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_pop_i && res_valid_q && state_q != B_OUT) res_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          arm_q <= 1'b0;
          if (q_valid_i) state_q <= B_DX2;
        end
        B_DX2:   state_q <= B_DY2;
        B_DY2:   state_q <= B_SUM2;
        B_SUM2:  state_q <= B_DIFF2;
        B_DIFF2: state_q <= B_L1SQ;
        B_L1SQ:  state_q <= B_L2SQ;
        B_L2SQ:  state_q <= B_L1L2;
        B_L1L2:  state_q <= B_CHECK;
        B_CHECK: begin
          if (d2_q > 36'(sumsq_q) || d2_q < 36'(diffsq_q)) begin
            ok_q    <= 1'b0;
            state_q <= B_OUT;
          end else begin
            state_q <= B_PROD;
          end
        end
        B_PROD:      state_q <= B_SQRT_GO;
        B_SQRT_GO:   state_q <= B_SQRT_WAIT;
        B_SQRT_WAIT: if (sq_done) state_q <= B_CY;
        B_CY:        state_q <= B_T;
        B_T:         state_q <= B_CX;
        B_CX:        state_q <= B_BETA_GO;
        B_BETA_GO:   state_q <= B_BETA_WAIT;
        B_BETA_WAIT: if (co_done) state_q <= B_ALPHA_GO;
        B_ALPHA_GO:  state_q <= B_ALPHA_WAIT;
        B_ALPHA_WAIT: if (co_done) state_q <= B_NEXT;
        B_NEXT: begin
          arm_q <= 1'b1;
          if (arm_q) begin
            ok_q    <= 1'b1;
            state_q <= B_OUT;
          end else begin
            state_q <= B_DX2;
          end
        end
        B_OUT: begin
          if (!res_valid_q || res_pop_i) begin
            res_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    unique case (state_q)
      B_IDLE:  tgt_q    <= q_data_i;
      B_DY2:   d2_q     <= 36'(p_q[34:0]);
      B_SUM2:  d2_q     <= d2_q + 36'(p_q[34:0]);
      B_DIFF2: sumsq_q  <= p_q[29:0];
      B_L1SQ:  diffsq_q <= p_q[27:0];
      B_L2SQ:  l1sq_q   <= p_q[27:0];
      B_L1L2:  l2sq_q   <= p_q[27:0];
      B_CHECK: begin
        den_q <= den_c;
        num_q <= num_w[31:0];
        dma_q <= den_c - an;
        dpa_q <= den_c + an;
      end
      B_SQRT_WAIT: if (sq_done) s_q <= sq_root;
      B_T:  cy_q <= p_q[47:0];
      B_CX: t_q  <= p_q[47:0];
      B_BETA_WAIT: if (co_done) begin
        if (arm_q) rb_q <= co_z;
        else       lb_q <= co_z;
      end
      B_ALPHA_WAIT: if (co_done) begin
        if (arm_q) ra_q <= co_z;
        else       la_q <= co_z;
      end
      B_OUT: begin
        if (!res_valid_q || res_pop_i) begin
          res_q.left_angle  <= ok_q ? motor_out(th_l) : 16'sd0;
          res_q.right_angle <= ok_q ? motor_out(th_r) : 16'sd0;
          res_q.reachable   <= ok_q;
          res_q.x           <= tgt_q.x;
          res_q.y           <= tgt_q.y;
        end
      end
      default: ;
    endcase
  end

  assign q_pop_o     = (state_q == B_IDLE) && q_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
endmodule

// ----- rtl/five_bar_scara_step_limit_ik_unit.sv -----
// Five-bar parallel SCARA step limiter and inverse kinematics, top level.
// Holds the configuration registers; depends on fbsik_pkg, fbsik_front,
// fbsik_queue and fbsik_back.
//
// Usage:
//   Requests enter like a queue write: an item is taken at a clock edge with
//   push high and full low. Results leave like a queue read: the oldest
//   result sits on the result ports while empty is low and is taken at an
//   edge with pop high.
//   The front (step limiter) runs a limited request through its 25-step square
//   root and two 15-step divisions; a request within max_step skips them. The
//   back (IK) uses 16 CORDIC steps: per arm a 30-step square root and two
//   CORDIC solves, plus the normalization shifts. An unreachable left arm ends
//   the solve early. The front can take the next request while the back is
//   still solving, as the target queue sits between them.
//   A two-entry target queue sits between front and back, and one result
//   register sits at the output; when the receiver stalls the back holds its
//   finished result and the front keeps filling the queue until it is full.
//   Reset loads the register defaults and the home target (0, 5173).
//   Configuration writes are to be made only while the block is idle; the block does not enforce it.
module five_bar_scara_step_limit_ik_unit
  import fbsik_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic signed [15:0]    request_x_i,
  input  logic signed [15:0]    request_y_i,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [15:0]    left_motor_angle_o,
  output logic signed [15:0]    right_motor_angle_o,
  output logic                  reachable_o,
  output logic signed [15:0]    limited_x_o,
  output logic signed [15:0]    limited_y_o
);
  logic [13:0] inner_q, outer_q, base_q, step_q;
  logic        q_push, q_full, q_pop, q_valid, res_valid;
  target_t     q_in, q_out;
  result_t     res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= INNER_LINK_RST;
      outer_q <= OUTER_LINK_RST;
      base_q  <= BASE_HALF_RST;
      step_q  <= MAX_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_INNER_LINK: inner_q <= cfg_data_i;
        CFG_OUTER_LINK: outer_q <= cfg_data_i;
        CFG_BASE_HALF:  base_q  <= cfg_data_i;
        CFG_MAX_STEP:   step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fbsik_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .request_x_i (request_x_i),
    .request_y_i (request_y_i),
    .max_step_i  (step_q),
    .q_push_o    (q_push),
    .q_full_i    (q_full),
    .q_data_o    (q_in)
  );

  fbsik_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  fbsik_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .inner_link_i (inner_q),
    .outer_link_i (outer_q),
    .base_half_i  (base_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_out),
    .q_pop_o      (q_pop),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .res_o        (res)
  );

  assign empty               = !res_valid;
  assign left_motor_angle_o  = res.left_angle;
  assign right_motor_angle_o = res.right_angle;
  assign reachable_o         = res.reachable;
  assign limited_x_o         = res.x;
  assign limited_y_o         = res.y;
endmodule

// ----- sim/fbsik_checker.sv -----
// Predicts and checks the five-bar SCARA step-limit IK unit's result beats.
// Depends on fbsik_pkg; watches the request, result and configuration ports.
module fbsik_checker
  import fbsik_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  input  logic                  full,
  input  logic signed [15:0]    request_x_i,
  input  logic signed [15:0]    request_y_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic signed [15:0]    left_motor_angle_o,
  input  logic signed [15:0]    right_motor_angle_o,
  input  logic                  reachable_o,
  input  logic signed [15:0]    limited_x_o,
  input  logic signed [15:0]    limited_y_o,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF_PI_Q24 = 64'd26353589;
  localparam longint TWO_PI_Q24  = 64'd105414357;

  // predictor copy of configuration and target
  longint link1, link2, half_span, step_max;
  longint tgt_x, tgt_y;
  result_t pose_q[$];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // vectoring CORDIC atan2, radians * 2^24
  function automatic longint vec_atan2(longint y, longint x);
    longint z, t, nx, ny, ax, ay, m;
    z = 0;
    if (x == 0 && y == 0) return 0;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    m = ax > ay ? ax : ay;
    while (m >= (64'sd1 <<< 41)) begin
      x = shr_floor(x, 1);
      y = shr_floor(y, 1);
      m = m >>> 1;
    end
    while (m < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HALF_PI_Q24;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI_Q24;
      end
    end
    for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += longint'(atan_q24(5'(i)));
      end else begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= longint'(atan_q24(5'(i)));
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic bit arm_angles(longint dx, longint dy, output longint alpha,
                                    output longint beta);
    longint d2, sum, diff, den, num, an, s;
    alpha = 0;
    beta = 0;
    d2 = dx * dx + dy * dy;
    sum = link1 + link2;
    diff = link2 >= link1 ? link2 - link1 : link1 - link2;
    if (d2 > sum * sum || d2 < diff * diff) return 0;
    den = 2 * link1 * link2;
    num = d2 - link1 * link1 - link2 * link2;
    an = num < 0 ? -num : num;
    if (an > den) an = den;
    s = int_sqrt(longint'(den - an) * longint'(den + an));
    beta = vec_atan2(link2 * s, link1 * den + link2 * num);
    alpha = vec_atan2(dy, dx);
    return 1;
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint a, q;
    if (d == 0) return 0;
    a = n < 0 ? -n : n;
    q = (2 * a + d) / (2 * d);
    return n < 0 ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [15:0] motor_cmd(longint th);
    if (th < 0) th += TWO_PI_Q24;
    return 16'(clamp(shr_floor(HALF_PI_Q24 - th + 2048, 12), -19302, 6434));
  endfunction

  // step-limit the target, then solve the left arm and, if it reaches, the right
  function automatic result_t next_pose(longint rx, longint ry);
    result_t r;
    longint dx, dy, d2, root_len, nx, ny, la, lb, ra, rb;
    bit ok;
    dx = rx - tgt_x;
    dy = ry - tgt_y;
    d2 = dx * dx + dy * dy;
    if (d2 > step_max * step_max) begin
      root_len = int_sqrt(d2 << 16);
      nx = tgt_x + div_round(dx * step_max * 256, root_len);
      ny = tgt_y + div_round(dy * step_max * 256, root_len);
    end else begin
      nx = rx;
      ny = ry;
    end
    tgt_x = clamp(nx, -32768, 32767);
    tgt_y = clamp(ny, -32768, 32767);
    ok = arm_angles(tgt_x + half_span, tgt_y, la, lb);
    if (ok) ok = arm_angles(tgt_x - half_span, tgt_y, ra, rb);
    r.left_angle = '0;
    r.right_angle = '0;
    if (ok) begin
      if (tgt_y >= 0) begin
        r.left_angle = motor_cmd(la + lb);
        r.right_angle = motor_cmd(ra - rb);
      end else begin
        r.left_angle = motor_cmd(la - lb);
        r.right_angle = motor_cmd(ra + rb);
      end
    end
    r.reachable = ok;
    r.x = 16'(tgt_x);
    r.y = 16'(tgt_y);
    return r;
  endfunction

  assign pending = pose_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      link1 = INNER_LINK_RST;
      link2 = OUTER_LINK_RST;
      half_span = BASE_HALF_RST;
      step_max = MAX_STEP_RST;
      tgt_x = TARGET_X_RST;
      tgt_y = TARGET_Y_RST;
      pose_q.delete();
      fail_count = 0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INNER_LINK: link1 = cfg_data_i;
          CFG_OUTER_LINK: link2 = cfg_data_i;
          CFG_BASE_HALF:  half_span = cfg_data_i;
          CFG_MAX_STEP:   step_max = cfg_data_i;
          default: ;
        endcase
      end
      // result beat
      if (pop && !empty) begin
        if (pose_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          if (left_motor_angle_o !== e.left_angle) begin
            $error("left_motor_angle exp %0d got %0d", e.left_angle, left_motor_angle_o);
            fail_count++;
          end
          if (right_motor_angle_o !== e.right_angle) begin
            $error("right_motor_angle exp %0d got %0d", e.right_angle,
                   right_motor_angle_o);
            fail_count++;
          end
          if (reachable_o !== e.reachable) begin
            $error("reachable exp %0d got %0d", e.reachable, reachable_o);
            fail_count++;
          end
          if (limited_x_o !== e.x) begin
            $error("limited_x exp %0d got %0d", e.x, limited_x_o);
            fail_count++;
          end
          if (limited_y_o !== e.y) begin
            $error("limited_y exp %0d got %0d", e.y, limited_y_o);
            fail_count++;
          end
        end
      end
      // request beat
      if (push && !full) pose_q.push_back(next_pose(request_x_i, request_y_i));
    end
  end
endmodule

// ----- sim/testbench.sv -----
// Stimulus and verdict for the five-bar SCARA step-limit IK unit.
// Depends on fbsik_pkg, five_bar_scara_step_limit_ik_unit and fbsik_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fbsik_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  pop = 1'b0;
  logic signed [15:0]    request_x_i = '0;
  logic signed [15:0]    request_y_i = '0;
  logic                  full, empty, reachable_o;
  logic signed [15:0]    left_motor_angle_o, right_motor_angle_o;
  logic signed [15:0]    limited_x_o, limited_y_o;
  int                    fail_count, pending;
  bit                    stim_done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  five_bar_scara_step_limit_ik_unit u_dut (.*);
  fbsik_checker u_chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 300);
  endfunction

  // receiver: random pop stalls, with stall-free stretches
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  task automatic write_reg(cfg_index_e idx, logic [13:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one request beat, pushed after an optional gap
  task automatic send_request(logic signed [15:0] x, logic signed [15:0] y, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push <= 1'b1;
    request_x_i <= x;
    request_y_i <= y;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // reachable-ish point near the workspace, or anywhere
  task automatic random_phase(int n, bit wide);
    logic signed [15:0] x, y;
    bit gaps;
    gaps = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if (wide || $urandom_range(0, 9) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'(int'($urandom_range(0, 8000)) - 4000);
        y = 16'(int'($urandom_range(0, 9000)) - 3000);
      end
      send_request(x, y, gaps);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, field extremes, walking the step limiter
    send_request(16'sd0, 16'sd5173, 1'b0);
    send_request(16'sd0, 16'sd5180, 1'b0);
    send_request(16'sd30, 16'sd5000, 1'b0);
    send_request(16'sh7fff, 16'sh7fff, 1'b0);
    send_request(-16'sh8000, -16'sh8000, 1'b0);
    send_request(16'sh7fff, -16'sh8000, 1'b0);
    send_request(-16'sh8000, 16'sh7fff, 1'b1);
    send_request(16'sd0, -16'sd1, 1'b1);
    drain();

    // big step, most requests reach in one beat; includes negative y and home
    write_reg(CFG_MAX_STEP, 14'h3fff);
    write_reg(CFG_BASE_HALF, 14'd0);
    send_request(16'sd0, 16'sd0, 1'b0);
    send_request(16'sd0, 16'sd3000, 1'b0);
    send_request(16'sd0, -16'sd3000, 1'b0);
    send_request(16'sd4800, 16'sd0, 1'b0);
    send_request(-16'sd1600, 16'sd0, 1'b0);
    send_request(16'sd32767, 16'sd32767, 1'b0);
    send_request(-16'sd2000, -16'sd1000, 1'b0);
    drain();

    // tiny and extreme links
    write_reg(CFG_INNER_LINK, 14'd1);
    write_reg(CFG_OUTER_LINK, 14'h3fff);
    write_reg(CFG_BASE_HALF, 14'h3fff);
    write_reg(CFG_MAX_STEP, 14'd1);
    random_phase(10, 1'b1);
    drain();
    write_reg(CFG_INNER_LINK, 14'h3fff);
    write_reg(CFG_OUTER_LINK, 14'h3fff);
    write_reg(CFG_MAX_STEP, 14'h3fff);
    random_phase(125, 1'b1);
    drain();

    // mainstream geometries with random requests
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_INNER_LINK, 14'($urandom_range(800, 3000)));
      write_reg(CFG_OUTER_LINK, 14'($urandom_range(1500, 5000)));
      write_reg(CFG_BASE_HALF, 14'($urandom_range(0, 1500)));
      write_reg(CFG_MAX_STEP, (p % 2) ? 14'($urandom_range(1, 200))
                                      : 14'($urandom_range(1000, 16383)));
      random_phase(100, p == 7);
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
